>>> hw/rtl/pom_pkg.sv
// Shared types, widths and reset constants of the perturb-and-observe tracker.
package pom_pkg;

   localparam int VOLT_W  = 16;
   localparam int CUR_W   = 16;
   localparam int POWER_W = 31;
   localparam int DUTY_W  = 7;
   localparam int STEP_W  = 4;
   localparam int FLOOR_W = 20;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_MIN    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_MAX    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_SIZE   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOISE_FLOOR = 2'd3;

   // Reset values of configuration and tracker state.
   localparam logic [DUTY_W-1:0]  DUTY_MIN_RESET    = 7'd10;
   localparam logic [DUTY_W-1:0]  DUTY_MAX_RESET    = 7'd50;
   localparam logic [STEP_W-1:0]  STEP_SIZE_RESET   = 4'd1;
   localparam logic [FLOOR_W-1:0] NOISE_FLOOR_RESET = 20'd1000;
   localparam logic [DUTY_W-1:0]  DUTY_RESET        = 7'd30;

   localparam logic [DUTY_W-1:0] PERCENT_LIMIT = 7'd100;

   // Module parameter defaults.
   localparam int PWM_PERIOD_DEFAULT = 100;
   localparam int FIFO_DEPTH_DEFAULT = 4;

   // Configuration as seen by the tracking stage.
   typedef struct packed {
      logic [DUTY_W-1:0]  duty_min;
      logic [DUTY_W-1:0]  duty_max;
      logic [STEP_W-1:0]  step_size;
      logic [FLOOR_W-1:0] noise_floor_uw;
   } cfg_type;

endpackage

>>> hw/rtl/pom_front.sv
// Front stage: accepts samples and registers their clamped power.
module pom_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [pom_pkg::VOLT_W-1:0]           req_panel_voltage_mv,
   input  logic signed [pom_pkg::CUR_W-1:0]     req_panel_current_ma,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output logic [pom_pkg::POWER_W-1:0]          push_power
);

   logic                            valid_ff;
   logic                            valid_in;
   logic [pom_pkg::POWER_W-1:0]     power_ff;
   logic [pom_pkg::POWER_W-1:0]     power_in;
   logic signed [pom_pkg::VOLT_W+pom_pkg::CUR_W:0] product;
   logic                            take;

   // The stage takes a new sample when empty or when its content moves on.
   assign req_ready = !valid_ff || push_ready;
   assign take      = req_valid && req_ready;

   // Voltage is unsigned, so it is widened with a zero sign bit.
   assign product  = $signed({1'b0, req_panel_voltage_mv}) * req_panel_current_ma;
   assign power_in = product[pom_pkg::VOLT_W+pom_pkg::CUR_W] ? '0
                                                             : product[pom_pkg::POWER_W-1:0];

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         power_ff <= power_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_power = power_ff;

endmodule

>>> hw/rtl/pom_fifo.sv
// Short power queue between the front stage and the tracking stage.
module pom_fifo #(
   parameter int DEPTH = pom_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   output logic                        push_ready,
   input  logic [pom_pkg::POWER_W-1:0] push_data,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output logic [pom_pkg::POWER_W-1:0] pop_data
);

   localparam int PTR_W   = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0]   LAST_PTR  = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   logic [pom_pkg::POWER_W-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               push, pop;

   assign push_ready = count_ff != FULL_COUNT;
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // Pointers wrap at the depth, which need not be a power of two.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/pom_back.sv
// Tracking stage: updates direction and duty and holds the result register.
module pom_back #(
   parameter int PWM_PERIOD = pom_pkg::PWM_PERIOD_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  pom_pkg::cfg_type            cfg,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  logic [pom_pkg::POWER_W-1:0] pop_power,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [pom_pkg::DUTY_W-1:0]  rsp_duty_ticks,
   output logic [pom_pkg::DUTY_W-1:0]  rsp_duty_percent,
   output logic [pom_pkg::POWER_W-1:0] rsp_power_uw
);

   localparam int DUTY_ENTRIES = 2 ** pom_pkg::DUTY_W;
   // Signed working width for duty plus or minus one step.
   localparam int WORK_W = pom_pkg::DUTY_W + 2;

   logic [pom_pkg::DUTY_W-1:0] pct_table [DUTY_ENTRIES];

   logic [pom_pkg::POWER_W-1:0] prev_power_ff;
   logic [pom_pkg::DUTY_W-1:0]  duty_ff, duty_in;
   logic                        step_down_ff, step_down_in;
   logic                        valid_ff, valid_in;
   logic [pom_pkg::DUTY_W-1:0]  out_duty_ff;
   logic [pom_pkg::DUTY_W-1:0]  out_pct_ff;
   logic [pom_pkg::POWER_W-1:0] out_power_ff;

   logic                        take;
   logic                        fell;
   logic [pom_pkg::POWER_W-1:0] change;
   logic                        perturb;
   logic signed [WORK_W-1:0]    duty_step;
   logic signed [WORK_W-1:0]    duty_hi;

   // Percent of period for every duty code, saturated at one hundred.
   for (genvar idx = 0; idx < DUTY_ENTRIES; idx++) begin : g_pct
      localparam int Raw = idx * 100 / PWM_PERIOD;
      assign pct_table[idx] = (Raw > 100) ? pom_pkg::PERCENT_LIMIT
                                          : pom_pkg::DUTY_W'(Raw);
   end

   assign pop_ready = !valid_ff || rsp_ready;
   assign take      = pop_valid && pop_ready;

   // Magnitude of the power change, taken in the direction that keeps it positive.
   assign fell    = pop_power < prev_power_ff;
   assign change  = fell ? prev_power_ff - pop_power : pop_power - prev_power_ff;
   assign perturb = change > pom_pkg::POWER_W'(cfg.noise_floor_uw);

   // Direction flips on a large fall; on any large change the duty steps, and it is always clamped.
   always_comb begin
      step_down_in = step_down_ff;
      if (perturb && fell) begin
         step_down_in = !step_down_ff;
      end
      duty_step = $signed({2'b00, duty_ff});
      if (perturb) begin
         if (step_down_in) begin
            duty_step = $signed({2'b00, duty_ff}) - $signed({5'd0, cfg.step_size});
         end else begin
            duty_step = $signed({2'b00, duty_ff}) + $signed({5'd0, cfg.step_size});
         end
      end
      duty_hi = duty_step;
      if (duty_step > $signed({2'b00, cfg.duty_max})) begin
         duty_hi = $signed({2'b00, cfg.duty_max});
      end
      duty_in = duty_hi[pom_pkg::DUTY_W-1:0];
      if (duty_hi < $signed({2'b00, cfg.duty_min})) begin
         duty_in = cfg.duty_min;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         prev_power_ff <= '0;
         duty_ff       <= pom_pkg::DUTY_RESET;
         step_down_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            prev_power_ff <= pop_power;
            duty_ff       <= duty_in;
            step_down_ff  <= step_down_in;
         end
      end
   end

   // Result register holds until the transfer on the response side.
   always_ff @(posedge clock) begin
      if (take) begin
         out_duty_ff  <= duty_in;
         out_pct_ff   <= pct_table[duty_in];
         out_power_ff <= pop_power;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_duty_ticks   = out_duty_ff;
   assign rsp_duty_percent = out_pct_ff;
   assign rsp_power_uw     = out_power_ff;

endmodule

>>> hw/rtl/perturb_observe_mppt_core.sv
// Top level of the perturb-and-observe maximum power point tracker.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_ready  panel_voltage_mv, panel_current_ma
//   rsp_      out        rsp_valid/rsp_ready  duty_ticks, duty_percent, power_uw
//   csr_      in         csr_write_enable     csr_index, csr_write_data
//
// One sample can be accepted every cycle while the response side is not stalled. Its
// response passes the power register, a queue entry and the result register before it
// is valid. The tracking stage updates duty combinationally from each power value it
// takes, which sets the one-item-per-cycle rate.
// Reset is synchronous and restores the default limits, duty 30 and upward stepping.
// A stalled response side fills the queue before the request side stops.
module perturb_observe_mppt_core #(
   parameter int PWM_PERIOD = pom_pkg::PWM_PERIOD_DEFAULT,
   parameter int FIFO_DEPTH = pom_pkg::FIFO_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [pom_pkg::VOLT_W-1:0]          req_panel_voltage_mv,
   input  logic signed [pom_pkg::CUR_W-1:0]    req_panel_current_ma,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pom_pkg::DUTY_W-1:0]          rsp_duty_ticks,
   output logic [pom_pkg::DUTY_W-1:0]          rsp_duty_percent,
   output logic [pom_pkg::POWER_W-1:0]         rsp_power_uw,
   input  logic                                csr_write_enable,
   input  logic [pom_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pom_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   pom_pkg::cfg_type            cfg_ff;
   logic                        push_valid, push_ready;
   logic [pom_pkg::POWER_W-1:0] push_power;
   logic                        pop_valid, pop_ready;
   logic [pom_pkg::POWER_W-1:0] pop_power;

   // Configuration registers keep the low bits of each write.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duty_min       <= pom_pkg::DUTY_MIN_RESET;
         cfg_ff.duty_max       <= pom_pkg::DUTY_MAX_RESET;
         cfg_ff.step_size      <= pom_pkg::STEP_SIZE_RESET;
         cfg_ff.noise_floor_uw <= pom_pkg::NOISE_FLOOR_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            pom_pkg::CSR_DUTY_MIN: begin
               cfg_ff.duty_min <= csr_write_data[pom_pkg::DUTY_W-1:0];
            end
            pom_pkg::CSR_DUTY_MAX: begin
               cfg_ff.duty_max <= csr_write_data[pom_pkg::DUTY_W-1:0];
            end
            pom_pkg::CSR_STEP_SIZE: begin
               cfg_ff.step_size <= csr_write_data[pom_pkg::STEP_W-1:0];
            end
            pom_pkg::CSR_NOISE_FLOOR: begin
               cfg_ff.noise_floor_uw <= csr_write_data[pom_pkg::FLOOR_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   pom_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_panel_voltage_mv (req_panel_voltage_mv),
      .req_panel_current_ma (req_panel_current_ma),
      .push_valid           (push_valid),
      .push_ready           (push_ready),
      .push_power           (push_power)
   );

   pom_fifo #(
      .DEPTH (FIFO_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_power),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_power)
   );

   pom_back #(
      .PWM_PERIOD (PWM_PERIOD)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .pop_valid        (pop_valid),
      .pop_ready        (pop_ready),
      .pop_power        (pop_power),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_duty_ticks   (rsp_duty_ticks),
      .rsp_duty_percent (rsp_duty_percent),
      .rsp_power_uw     (rsp_power_uw)
   );

endmodule

>>> hw/rtl/pom_checker.sv
// Port-level checks of the tracker, bound to its top level.
module pom_checker #(
   parameter int PWM_PERIOD = pom_pkg::PWM_PERIOD_DEFAULT
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [pom_pkg::DUTY_W-1:0]          rsp_duty_ticks,
   input logic [pom_pkg::DUTY_W-1:0]          rsp_duty_percent,
   input logic [pom_pkg::POWER_W-1:0]         rsp_power_uw
);

   localparam int PERCENT_SCALE = 100;

   int   ticks_scaled;
   int   pct_scaled;
   logic pct_ok;

   // Percent must be the truncated quotient of ticks over period, or the limit when
   // that quotient reaches it.
   assign ticks_scaled = int'(rsp_duty_ticks) * PERCENT_SCALE;
   assign pct_scaled   = int'(rsp_duty_percent) * PWM_PERIOD;
   assign pct_ok = (rsp_duty_percent == pom_pkg::PERCENT_LIMIT) ?
                      (ticks_scaled >= pct_scaled) :
                      (rsp_duty_percent < pom_pkg::PERCENT_LIMIT &&
                       ticks_scaled >= pct_scaled &&
                       ticks_scaled < pct_scaled + PWM_PERIOD);

   // A response waiting for its transfer keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_duty_ticks)
         && $stable(rsp_duty_percent) && $stable(rsp_power_uw))
      else $error("response changed while stalled");

   // Nothing is reported in the cycle after reset.
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // Percent agrees with the reported duty ticks.
   a_pct_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pct_ok)
      else $error("duty percent does not match duty ticks");

   // With no response pending, the request side still keeps taking samples.
   a_req_flows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && $past(!rsp_valid) && !$past(reset) |-> req_ready)
      else $error("request side stalled with an empty pipeline");

endmodule

bind perturb_observe_mppt_core pom_checker #(
   .PWM_PERIOD (PWM_PERIOD)
) u_pom_checker (.*);
